>>> rtl/utd_pkg.sv
// Shared types and constants for the UTF-8 to UTF-32 decoder.
package utd_pkg;

    localparam int unsigned CP_BITS  = 21;
    localparam int unsigned OUT_CNT_BITS = 16;

    // Lead byte ranges
    localparam logic [7:0] LEAD2_MIN   = 8'hC2;  // C0/C1 are forbidden
    localparam logic [7:0] LEAD3_MIN   = 8'hE0;
    localparam logic [7:0] LEAD4_MIN   = 8'hF0;
    localparam logic [7:0] LEAD_BAD_MIN = 8'hF5; // F5-FF are forbidden
    localparam logic [1:0] CONT_TAG    = 2'b10;

    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_ONE   = 2'd1;
    localparam logic [1:0] PEND_TWO   = 2'd2;
    localparam logic [1:0] PEND_THREE = 2'd3;

    typedef struct packed {
        logic [1:0]         pending;
        logic [CP_BITS-1:0] partial;
        logic               err;
    } t_dec_state;

    typedef struct packed {
        logic               valid;
        logic [CP_BITS-1:0] code_point;
        logic               status;
        logic               eos;
    } t_dec_result;

endpackage

>>> rtl/utf8_to_utf32_decoder_top.sv
// Top level of the streaming UTF-8 to UTF-32 decoder.
//
// Input stream: one UTF-8 byte per item on s_axis_tdata, s_axis_tlast on the
// final byte of a string. Output stream: one item per completed code point or
// final byte of a string (one item when both hold). m_axis_tlast marks that
// end item; m_axis_tuser is the status (1 = the string had an encoding error,
// code point then reads 0). The count field is the number of code points
// decoded so far in the string, saturating, including the one in the item.
// Bytes after an error are dropped until the final byte of the string.
//
// Timing: input register, then the decode step and result register. A byte waits
// in the input register until the step advances and writes its result. One byte
// is taken per cycle while the receiver keeps up; the decode step is combinational.
// When the receiver stalls, the result register holds and the input register
// still takes one more byte; tready drops once both are occupied.
// Reset (synchronous, active low) empties both registers and clears the
// string state, so decoding starts at a fresh string.
module utf8_to_utf32_decoder_top #(
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // in_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [20:0] code_point, [36:21] decoded_count, zero pad
    output logic [0:0]  m_axis_tuser,   // [0] status
    output logic        m_axis_tlast    // end_of_string
);
    import utd_pkg::*;

    localparam int unsigned EXT_BITS = (COUNT_BITS > OUT_CNT_BITS) ? COUNT_BITS : OUT_CNT_BITS;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // string state
    t_dec_state            r_state, n_state;
    logic [COUNT_BITS-1:0] r_tally, n_tally;

    // result register
    logic                    r_out_valid;
    logic [CP_BITS-1:0]      r_out_cp;
    logic [OUT_CNT_BITS-1:0] r_out_cnt;
    logic                    r_out_status;
    logic                    r_out_eos;

    t_dec_result           step_res;
    logic [COUNT_BITS-1:0] step_cnt;
    logic [EXT_BITS-1:0]   cnt_ext;
    logic                  advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    utd_step #(
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .i_state  (r_state),
        .i_tally  (r_tally),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_state  (n_state),
        .o_tally  (n_tally),
        .o_result (step_res),
        .o_count  (step_cnt)
    );

    assign cnt_ext = EXT_BITS'(step_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_tally <= '0;
        end else if (advance) begin
            r_state <= n_state;
            r_tally <= n_tally;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step_res.valid;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && step_res.valid) begin
            r_out_cp     <= step_res.code_point;
            r_out_cnt    <= cnt_ext[OUT_CNT_BITS-1:0];
            r_out_status <= step_res.status;
            r_out_eos    <= step_res.eos;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'd0, r_out_cnt, r_out_cp};
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_eos;

    // error items only ever close a string
    a_err_is_end : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
        else $error("error status on an item that is not end of string");

    a_err_zero_cp : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[20:0] == '0))
        else $error("error item carries a nonzero code point");

    a_clear_after_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_last) |=> (r_state == '0 && r_tally == '0))
        else $error("string state not cleared after final byte");

    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && r_in_valid) |-> advance)
        else $error("input register overwritten while holding an item");

    a_result_kept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !advance)
        else $error("stalled result overwritten");

endmodule

>>> rtl/utd_step.sv
// One decode step: current string state and one byte in, next state and result out.
module utd_step #(
    parameter int unsigned COUNT_BITS = 16
) (
    input  utd_pkg::t_dec_state  i_state,
    input  logic [COUNT_BITS-1:0] i_tally,
    input  logic [7:0]            i_byte,
    input  logic                  i_last,
    output utd_pkg::t_dec_state  o_state,
    output logic [COUNT_BITS-1:0] o_tally,
    output utd_pkg::t_dec_result o_result,
    output logic [COUNT_BITS-1:0] o_count
);
    import utd_pkg::*;

    localparam logic [COUNT_BITS-1:0] ONE = COUNT_BITS'(1);

    t_dec_state              n_state;
    logic                    done;
    logic [COUNT_BITS-1:0]   tally_inc;

    always_comb begin
        n_state = i_state;
        done    = 1'b0;
        if (!i_state.err) begin
            if (i_state.pending == PEND_NONE) begin
                priority if (!i_byte[7]) begin
                    n_state.partial = {13'd0, i_byte};
                    done            = 1'b1;
                end else if (i_byte < LEAD2_MIN || i_byte >= LEAD_BAD_MIN) begin
                    // stray continuation or forbidden lead
                    n_state.err = 1'b1;
                end else if (i_byte < LEAD3_MIN) begin
                    n_state.partial = {16'd0, i_byte[4:0]};
                    n_state.pending = PEND_ONE;
                end else if (i_byte < LEAD4_MIN) begin
                    n_state.partial = {17'd0, i_byte[3:0]};
                    n_state.pending = PEND_TWO;
                end else begin
                    n_state.partial = {18'd0, i_byte[2:0]};
                    n_state.pending = PEND_THREE;
                end
            end else begin
                if (i_byte[7:6] != CONT_TAG) begin
                    n_state.err = 1'b1;
                end else begin
                    n_state.partial = {i_state.partial[CP_BITS-7:0], i_byte[5:0]};
                    n_state.pending = i_state.pending - PEND_ONE;
                    done            = (i_state.pending == PEND_ONE);
                end
            end
        end
    end

    assign tally_inc = (&i_tally) ? i_tally : i_tally + ONE;

    always_comb begin
        o_result.valid      = done || i_last;
        o_result.code_point = done ? n_state.partial : '0;
        o_result.status     = !done;
        o_result.eos        = i_last;
        o_count             = done ? tally_inc : i_tally;

        o_state = n_state;
        o_tally = o_count;
        if (done) begin
            o_state.partial = '0;
        end
        if (i_last) begin
            o_state = '0;
            o_tally = '0;
        end
    end

endmodule
